### rtl/rsf_pkg.sv
package rsf_pkg;

  localparam int AMP_W         = 13;
  localparam int SUM_W         = 21;
  localparam int SQ_W          = 32;
  localparam int FLAT_W        = 17;
  localparam int ONE_Q16       = 65536;
  localparam int DEF_NUM_CELLS = 208;

  // restoring divide gives 32 fraction bits, quotient can reach 2^32
  localparam int DIV_STEPS  = 32;
  localparam int Q_W        = DIV_STEPS + 1;
  localparam int SQRT_STEPS = (Q_W + 1) / 2;
  localparam int R_W        = Q_W + 1;

  localparam int STEP_W = 4;
  localparam int LCNT_W = $clog2(DIV_STEPS);

  // program labels
  localparam logic [STEP_W-1:0] ST_IDLE  = STEP_W'(0);
  localparam logic [STEP_W-1:0] ST_SQ    = STEP_W'(1);
  localparam logic [STEP_W-1:0] ST_NQ    = STEP_W'(2);
  localparam logic [STEP_W-1:0] ST_M     = STEP_W'(3);
  localparam logic [STEP_W-1:0] ST_DINIT = STEP_W'(4);
  localparam logic [STEP_W-1:0] ST_CHECK = STEP_W'(5);
  localparam logic [STEP_W-1:0] ST_DIV   = STEP_W'(6);
  localparam logic [STEP_W-1:0] ST_SINIT = STEP_W'(7);
  localparam logic [STEP_W-1:0] ST_SQRT  = STEP_W'(8);
  localparam logic [STEP_W-1:0] ST_EMIT  = STEP_W'(9);

  typedef enum logic [3:0] {
    OP_NOP,
    OP_SQ,
    OP_NQ,
    OP_M,
    OP_DINIT,
    OP_DIV0,
    OP_DIVSTEP,
    OP_SINIT,
    OP_SQRTSTEP,
    OP_EMIT
  } op_t;

  typedef enum logic [2:0] {
    JC_NEXT,
    JC_NOGO,
    JC_INVALID,
    JC_LOOP,
    JC_EMIT
  } jc_t;

  typedef struct packed {
    op_t               op;
    jc_t               jc;
    logic [STEP_W-1:0] target;
    logic              load_cnt;
    logic [LCNT_W-1:0] cnt_value;
  } ctrl_word_t;

  // what the sequencer hands to the rest of the block each cycle
  typedef struct packed {
    op_t  op;
    logic emit;
    logic idle;
  } seq_ctrl_t;

  function automatic ctrl_word_t useq_rom(input logic [STEP_W-1:0] step);
    ctrl_word_t cw;
    cw = '{op: OP_NOP, jc: JC_NEXT, target: ST_IDLE, load_cnt: 1'b0, cnt_value: '0};
    case (step)
      ST_IDLE:  begin cw.jc = JC_NOGO; cw.target = ST_IDLE; end
      ST_SQ:    cw.op = OP_SQ;
      ST_NQ:    cw.op = OP_NQ;
      ST_M:     cw.op = OP_M;
      ST_DINIT: begin
        cw.op        = OP_DINIT;
        cw.load_cnt  = 1'b1;
        cw.cnt_value = LCNT_W'(DIV_STEPS - 1);
      end
      ST_CHECK: begin cw.op = OP_DIV0; cw.jc = JC_INVALID; cw.target = ST_EMIT; end
      ST_DIV:   begin cw.op = OP_DIVSTEP; cw.jc = JC_LOOP; cw.target = ST_DIV; end
      ST_SINIT: begin
        cw.op        = OP_SINIT;
        cw.load_cnt  = 1'b1;
        cw.cnt_value = LCNT_W'(SQRT_STEPS - 1);
      end
      ST_SQRT:  begin cw.op = OP_SQRTSTEP; cw.jc = JC_LOOP; cw.target = ST_SQRT; end
      ST_EMIT:  begin cw.op = OP_EMIT; cw.jc = JC_EMIT; cw.target = ST_IDLE; end
      default:  begin cw.jc = JC_EMIT; cw.target = ST_IDLE; cw.op = OP_NOP; end
    endcase
    return cw;
  endfunction

endpackage

### rtl/rsf_accum.sv
module rsf_accum
  import rsf_pkg::*;
#(
  parameter int NUM_CELLS = DEF_NUM_CELLS
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    accept,
  input  logic signed [AMP_W-1:0] amplitude,
  input  logic                    last_cell,
  input  logic                    clear,
  output logic signed [SUM_W-1:0] amplitude_sum,
  output logic [SQ_W-1:0]         square_sum,
  output logic                    overflow_seen,
  output logic                    done
);

  localparam int CNT_W = $clog2(NUM_CELLS + 1);

  logic [CNT_W-1:0]          cell_counter;
  logic [2*AMP_W-1:0]        amp_sq;

  // signed operands are extended to the full product width
  assign amp_sq = amplitude * amplitude;

  always_ff @(posedge clk) begin
    if (rst || clear) begin
      cell_counter  <= '0;
      amplitude_sum <= '0;
      square_sum    <= '0;
      overflow_seen <= 1'b0;
      done          <= 1'b0;
    end else if (accept) begin
      if (cell_counter < CNT_W'(NUM_CELLS)) begin
        amplitude_sum <= amplitude_sum + SUM_W'(amplitude);
        square_sum    <= square_sum + SQ_W'(amp_sq);
        cell_counter  <= cell_counter + CNT_W'(1);
      end else begin
        overflow_seen <= 1'b1;
      end
      if (last_cell) begin
        done <= 1'b1;
      end
    end
  end

endmodule

### rtl/rsf_useq.sv
module rsf_useq
  import rsf_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      go,
  input  logic      valid,
  input  logic      can_emit,
  output seq_ctrl_t ctrl
);

  logic [STEP_W-1:0] step, step_next;
  logic [LCNT_W-1:0] loop_cnt, loop_cnt_next;
  ctrl_word_t        cw;

  assign cw = useq_rom(step);

  always_comb begin
    step_next     = step + STEP_W'(1);
    loop_cnt_next = loop_cnt;
    case (cw.jc)
      JC_NEXT:    step_next = step + STEP_W'(1);
      JC_NOGO:    step_next = go ? step + STEP_W'(1) : cw.target;
      JC_INVALID: step_next = valid ? step + STEP_W'(1) : cw.target;
      JC_LOOP: begin
        if (loop_cnt != '0) begin
          step_next     = cw.target;
          loop_cnt_next = loop_cnt - LCNT_W'(1);
        end
      end
      JC_EMIT:    step_next = can_emit ? cw.target : step;
      default:    step_next = ST_IDLE;
    endcase
    if (cw.load_cnt) begin
      loop_cnt_next = cw.cnt_value;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      step     <= ST_IDLE;
      loop_cnt <= '0;
    end else begin
      step     <= step_next;
      loop_cnt <= loop_cnt_next;
    end
  end

  assign ctrl.op   = cw.op;
  assign ctrl.emit = (cw.op == OP_EMIT) && can_emit;
  assign ctrl.idle = (step == ST_IDLE);

endmodule

### rtl/rsf_datapath.sv
module rsf_datapath
  import rsf_pkg::*;
#(
  parameter int NUM_CELLS = DEF_NUM_CELLS
) (
  input  logic                    clk,
  input  logic                    rst,
  input  seq_ctrl_t               ctrl,
  input  logic signed [SUM_W-1:0] amplitude_sum,
  input  logic [SQ_W-1:0]         square_sum,
  output logic                    valid,
  output logic [FLAT_W-1:0]       flatness
);

  localparam int CNT_W = $clog2(NUM_CELLS + 1);
  localparam int S2_W  = 2 * SUM_W - 1;
  localparam int NQ_W  = SQ_W + CNT_W;
  localparam int D_W   = ((NQ_W > S2_W) ? NQ_W : S2_W) + 1;
  localparam int M_W   = S2_W + CNT_W;
  localparam int REM_W = M_W + 1;

  localparam logic [CNT_W-1:0] NCELLS = CNT_W'(NUM_CELLS);

  logic [S2_W-1:0]  sq;
  logic [NQ_W-1:0]  nq;
  logic [M_W-1:0]   m;
  logic [REM_W-1:0] rem;
  logic [Q_W-1:0]   q;
  logic [Q_W-1:0]   x;
  logic [R_W-1:0]   res;
  logic [Q_W-1:0]   sbit;

  logic [D_W-1:0]   d_full;
  logic [D_W-2:0]   d;
  logic [REM_W-1:0] rem_sh;
  logic [R_W:0]     trial;
  logic [FLAT_W:0]  flat_full;

  // n*q - s*s, clamped at zero
  assign d_full    = D_W'(nq) - D_W'(sq);
  assign d         = d_full[D_W-1] ? '0 : d_full[D_W-2:0];
  assign rem_sh    = {rem[REM_W-2:0], 1'b0};
  assign trial     = (R_W+1)'(res) + (R_W+1)'(sbit);
  assign flat_full = (FLAT_W+1)'(ONE_Q16) - (FLAT_W+1)'(res[FLAT_W-1:0]);
  assign flatness  = valid ? flat_full[FLAT_W-1:0] : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (ctrl.op == OP_DINIT) begin
      valid <= (amplitude_sum > 0) && ((M_W+1)'(d) <= (M_W+1)'(m));
    end
  end

  always_ff @(posedge clk) begin
    case (ctrl.op)
      OP_SQ: sq <= amplitude_sum * amplitude_sum;
      OP_NQ: nq <= NQ_W'(NCELLS) * NQ_W'(square_sum);
      OP_M:  m  <= M_W'(NCELLS) * M_W'(sq);
      OP_DINIT: begin
        rem <= REM_W'(d);
        q   <= '0;
      end
      OP_DIV0: begin
        if (rem >= REM_W'(m)) begin
          rem <= rem - REM_W'(m);
          q   <= Q_W'(1);
        end
      end
      OP_DIVSTEP: begin
        if (rem_sh >= REM_W'(m)) begin
          rem <= rem_sh - REM_W'(m);
          q   <= {q[Q_W-2:0], 1'b1};
        end else begin
          rem <= rem_sh;
          q   <= {q[Q_W-2:0], 1'b0};
        end
      end
      OP_SINIT: begin
        x    <= q;
        res  <= '0;
        sbit <= {1'b1, {(Q_W-1){1'b0}}};
      end
      OP_SQRTSTEP: begin
        // one result bit per step
        if ((R_W+1)'(x) >= trial) begin
          x   <= Q_W'((R_W+1)'(x) - trial);
          res <= (res >> 1) + R_W'(sbit);
        end else begin
          res <= res >> 1;
        end
        sbit <= sbit >> 2;
      end
      default: ;
    endcase
  end

endmodule

### rtl/relative_spread_flatness_top.sv
// accepts one amplitude per cycle while an event streams in
// after the item with tlast, the microcode program runs its setup steps (square, n*q, m,
// divide init, check), 32 divide steps, square-root init and 17 square-root steps, then emit
// when the sum is not positive or the spread exceeds the mean, check jumps straight to emit
// no input is taken from the last item until its result enters the output register
// synchronous reset clears the accumulators, returns the program to idle, empties the output
module relative_spread_flatness_top
  import rsf_pkg::*;
#(
  parameter int NUM_CELLS = DEF_NUM_CELLS
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [15:0] s_tdata,   // [12:0] amplitude
  input  logic        s_tlast,
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [23:0] m_tdata,   // [16:0] flatness
  output logic [1:0]  m_tuser    // [0] result_valid, [1] excess_cells
);

  seq_ctrl_t               ctrl;
  logic                    accept;
  logic                    done;
  logic signed [SUM_W-1:0] amplitude_sum;
  logic [SQ_W-1:0]         square_sum;
  logic                    overflow_seen;
  logic                    dp_valid;
  logic [FLAT_W-1:0]       dp_flatness;
  logic                    can_emit;

  logic                    out_valid;
  logic                    out_result_valid;
  logic [FLAT_W-1:0]       out_flatness;
  logic                    out_excess;

  assign s_tready = ctrl.idle && !done;
  assign accept   = s_tvalid && s_tready;
  assign can_emit = !out_valid || m_tready;

  rsf_accum #(.NUM_CELLS(NUM_CELLS)) u_accum (
    .clk           (clk),
    .rst           (rst),
    .accept        (accept),
    .amplitude     ($signed(s_tdata[AMP_W-1:0])),
    .last_cell     (s_tlast),
    .clear         (ctrl.emit),
    .amplitude_sum (amplitude_sum),
    .square_sum    (square_sum),
    .overflow_seen (overflow_seen),
    .done          (done)
  );

  rsf_useq u_useq (
    .clk      (clk),
    .rst      (rst),
    .go       (done),
    .valid    (dp_valid),
    .can_emit (can_emit),
    .ctrl     (ctrl)
  );

  rsf_datapath #(.NUM_CELLS(NUM_CELLS)) u_datapath (
    .clk           (clk),
    .rst           (rst),
    .ctrl          (ctrl),
    .amplitude_sum (amplitude_sum),
    .square_sum    (square_sum),
    .valid         (dp_valid),
    .flatness      (dp_flatness)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ctrl.emit) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.emit) begin
      out_result_valid <= dp_valid;
      out_flatness     <= dp_flatness;
      out_excess       <= overflow_seen;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {{(24-FLAT_W){1'b0}}, out_flatness};
  assign m_tuser  = {out_excess, out_result_valid};

  // an invalid result carries zero flatness
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tuser[0] |-> m_tdata[16:0] == 17'd0)
    else $error("invalid result with nonzero flatness");

  // flatness never exceeds 1.0
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata[16:0] <= 17'(ONE_Q16))
    else $error("flatness above one");

  // the closing transaction of an event stops intake until the result is loaded
  assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready && s_tlast |=> !s_tready)
    else $error("input taken during result computation");

  // results are loaded from the emit step only once an event has finished
  assert property (@(posedge clk) disable iff (rst)
    ctrl.emit |-> done)
    else $error("result emitted without a finished event");

endmodule

### test/tb_top.sv
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import rsf_pkg::*;

  localparam int CELLS = DEF_NUM_CELLS;

  typedef struct packed {
    logic              ok;
    logic [FLAT_W-1:0] flat;
    logic              spill;
  } flatness_t;

  typedef enum int {
    AMP_ANY,
    AMP_NEAR,
    AMP_POS,
    AMP_EDGE,
    AMP_FIXED
  } amp_mix_t;

  logic        clk;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [15:0] s_tdata;    // [12:0] amplitude
  logic        s_tlast;
  logic        m_tvalid;
  logic        m_tready;
  logic [23:0] m_tdata;    // [16:0] flatness
  logic [1:0]  m_tuser;    // [0] result_valid, [1] excess_cells

  relative_spread_flatness_top #(
    .NUM_CELLS(CELLS)
  ) dut (
    .clk     (clk),
    .rst     (rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata (s_tdata),
    .s_tlast (s_tlast),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata),
    .m_tuser (m_tuser)
  );

  // event accumulators of the predictor
  logic [7:0]              cells_taken;
  logic signed [SUM_W-1:0] run_sum;
  logic [SQ_W-1:0]         run_sq;
  logic                    spill_seen;

  flatness_t results_due[$];
  int        errors = 0;
  bit        tx_steady;
  bit        rx_steady;

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  function automatic void clear_tracker();
    cells_taken = '0;
    run_sum     = '0;
    run_sq      = '0;
    spill_seen  = 1'b0;
  endfunction

  function automatic logic [16:0] floor_root(logic [32:0] v);
    logic [16:0] res;
    logic [16:0] t;
    res = '0;
    for (int b = 16; b >= 0; b--) begin
      t = res | (17'd1 << b);
      if (longint'(t) * longint'(t) <= longint'({31'd0, v})) res = t;
    end
    return res;
  endfunction

  function automatic void track_cell(logic signed [AMP_W-1:0] amp, logic last);
    longint      a;
    longint      s;
    longint      d;
    longint      m;
    logic [127:0] quo;
    flatness_t   r;
    a = amp;
    if (cells_taken < CELLS) begin
      run_sum     = run_sum + SUM_W'(a);
      run_sq      = run_sq + SQ_W'(a * a);
      cells_taken = cells_taken + 8'd1;
    end else begin
      spill_seen = 1'b1;
    end
    if (!last) return;
    r = '0;
    r.spill = spill_seen;
    s = run_sum;
    if (s > 0) begin
      d = longint'(CELLS) * longint'({32'd0, run_sq}) - s * s;
      if (d < 0) d = 0;
      m = longint'(CELLS) * s * s;
      // spread at most the mean: quotient stays within 2^32
      if (d <= m) begin
        quo    = (128'(d) << 32) / 128'(m);
        r.flat = FLAT_W'(ONE_Q16 - int'(floor_root(quo[32:0])));
        r.ok   = 1'b1;
      end
    end
    results_due.insert(results_due.size(), r);
    clear_tracker();
  endfunction

  task automatic send_cell(input logic signed [AMP_W-1:0] amp, input logic last);
    int gap;
    gap = tx_steady ? 0 : $urandom_range(0, 6);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {3'b000, amp};
    s_tlast  <= last;
    do @(posedge clk); while (!s_tready);
    track_cell(amp, last);
  endtask

  task automatic send_cells(input int vals[$]);
    for (int i = 0; i < vals.size(); i++)
      send_cell(AMP_W'(vals[i]), i == vals.size() - 1);
  endtask

  function automatic logic signed [AMP_W-1:0] pick_amp(amp_mix_t mix, int base);
    int v;
    case (mix)
      AMP_ANY:  v = int'($urandom_range(0, 8191)) - 4096;
      AMP_NEAR: begin
        v = base + int'($urandom_range(0, 16)) - 8;
        if (v > 4095) v = 4095;
      end
      AMP_POS:  v = $urandom_range(0, 4095);
      AMP_EDGE: begin
        case ($urandom_range(0, 4))
          0:       v = -4096;
          1:       v = -1;
          2:       v = 0;
          3:       v = 1;
          default: v = 4095;
        endcase
      end
      default:  v = base;
    endcase
    return AMP_W'(v);
  endfunction

  task automatic send_event(input int len, input amp_mix_t mix, input int base);
    for (int i = 0; i < len; i++)
      send_cell(pick_amp(mix, base), i == len - 1);
  endtask

  // stop sending until every pending result has been taken
  task automatic wait_results_drained();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (results_due.size() != 0) @(posedge clk);
  endtask

  task automatic test_directed();
    int cells[$];
    cells = {4095};                        send_cells(cells);
    cells = {-4096};                       send_cells(cells);
    // zero sum
    cells = {5, -5};                       send_cells(cells);
    cells = {0};                           send_cells(cells);
    // spread above the mean
    cells = {1, 100, -100};                send_cells(cells);
    // spread exactly equal to the mean
    cells = {104, 5, -5, 1, -1};           send_cells(cells);
    cells = {4095, 4095, 4095, 4094};      send_cells(cells);
    cells = {-1, 3};                       send_cells(cells);
    cells = {2048, 2047, -4096, 4095, 1};  send_cells(cells);
  endtask

  task automatic test_full_events();
    send_event(CELLS, AMP_FIXED, 4095);     // perfectly flat, flatness 1.0
    send_event(CELLS + 1, AMP_FIXED, 7);    // last item is the first ignored one
    send_event(CELLS + 7, AMP_POS, 0);
    send_event(CELLS, AMP_NEAR, 3000);
  endtask

  task automatic test_drain_pause();
    for (int k = 0; k < 4; k++) begin
      send_event($urandom_range(1, 10), amp_mix_t'($urandom_range(0, 3)),
                 $urandom_range(1, 4095));
      wait_results_drained();
    end
  endtask

  task automatic test_random_events();
    int sent;
    int len;
    int pick;
    sent = 0;
    while (sent < 620) begin
      pick = $urandom_range(0, 99);
      if (pick < 80)      len = $urandom_range(1, 12);
      else if (pick < 90) len = $urandom_range(13, CELLS - 1);
      else if (pick < 96) len = CELLS;
      else                len = $urandom_range(CELLS + 1, CELLS + 12);
      tx_steady = ($urandom_range(0, 4) == 0);
      send_event(len, amp_mix_t'($urandom_range(0, 3)), $urandom_range(1, 4095));
      sent += len;
    end
    tx_steady = 1'b0;
  endtask

  initial begin
    tx_steady = 1'b0;
    rst      <= 1'b1;
    s_tvalid <= 1'b0;
    s_tdata  <= '0;
    s_tlast  <= 1'b0;
    clear_tracker();
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    test_directed();
    wait_results_drained();
    test_full_events();
    wait_results_drained();
    test_drain_pause();
    test_random_events();
    wait_results_drained();
    repeat (100) @(posedge clk);
    if (errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  initial begin : result_monitor
    int        gap;
    flatness_t want;
    m_tready <= 1'b0;
    rx_steady = 1'b0;
    do @(posedge clk); while (rst);
    forever begin
      if ($urandom_range(0, 9) == 0) rx_steady = !rx_steady;
      gap = rx_steady ? 0 : $urandom_range(0, 6);
      if (rx_steady || $urandom_range(0, 1) == 0) begin
        if (gap > 0) begin
          m_tready <= 1'b0;
          repeat (gap) @(posedge clk);
        end
      end else begin
        // hold off while a result is already offered
        m_tready <= 1'b0;
        do @(posedge clk); while (!m_tvalid);
        repeat (gap) @(posedge clk);
      end
      m_tready <= 1'b1;
      do @(posedge clk); while (!m_tvalid);
      if (results_due.size() == 0) begin
        errors++;
        $display("%0t unexpected transaction: flatness %0d valid %0b excess %0b", $time,
                 m_tdata[FLAT_W-1:0], m_tuser[0], m_tuser[1]);
      end else begin
        want = results_due.pop_front();
        if (m_tuser[0] !== want.ok) begin
          errors++;
          $display("%0t result_valid expected %0b got %0b", $time, want.ok, m_tuser[0]);
        end
        if (m_tdata[FLAT_W-1:0] !== want.flat) begin
          errors++;
          $display("%0t flatness expected %0d got %0d", $time, want.flat,
                   m_tdata[FLAT_W-1:0]);
        end
        if (m_tuser[1] !== want.spill) begin
          errors++;
          $display("%0t excess_cells expected %0b got %0b", $time, want.spill, m_tuser[1]);
        end
      end
    end
  end

  initial begin
    #20ms;
    $display("tb: failure");
    $finish;
  end

endmodule

### sim.f
rtl/rsf_pkg.sv
rtl/rsf_accum.sv
rtl/rsf_useq.sv
rtl/rsf_datapath.sv
rtl/relative_spread_flatness_top.sv
test/tb_top.sv
